// ----- src/bdke_pkg.sv -----
// shared types and constants for the key debounce event encoder
`default_nettype none

package bdke_pkg;

    localparam int DEF_WINDOW_SAMPLES = 16;
    localparam int DEF_KEY_COUNT      = 8;

    localparam int PORT_W  = 8;
    localparam int STATE_W = 7;
    localparam int KEYCH_W = 6;

    localparam logic [STATE_W-1:0] CHAR_DOWN = 7'd68;
    localparam logic [STATE_W-1:0] CHAR_UP   = 7'd85;
    localparam logic [KEYCH_W-1:0] CHAR_ZERO = 6'd48;

    // one debounced change: new key levels and the keys that moved
    typedef struct packed {
        logic [PORT_W-1:0] keys;
        logic [PORT_W-1:0] changed;
    } packet_t;

endpackage

`default_nettype wire

// ----- src/bdke_front.sv -----
// sampling window, stability check and change detection
`default_nettype none

module bdke_front #(
    parameter int WINDOW_SAMPLES = bdke_pkg::DEF_WINDOW_SAMPLES,
    parameter int KEY_COUNT      = bdke_pkg::DEF_KEY_COUNT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [bdke_pkg::PORT_W-1:0] raw_port,
    output logic                             pkt_valid,
    input  wire logic                        pkt_ready,
    output bdke_pkg::packet_t                pkt
);
    import bdke_pkg::*;

    localparam int POS_W = $clog2(WINDOW_SAMPLES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_SAMPLES - 1);
    localparam logic [PORT_W-1:0] KEY_MASK = PORT_W'((16'd1 << KEY_COUNT) - 16'd1);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [PORT_W-1:0] first_reg, first_next;
    logic              stable_reg, stable_next;
    logic [PORT_W-1:0] deb_reg, deb_next;

    logic [PORT_W-1:0] sample;
    logic              accept;
    logic              fire;

    assign s_tready = pkt_ready;
    assign accept   = s_tvalid && s_tready;
    assign sample   = ~raw_port & KEY_MASK;

    always_comb
    begin
        pos_next    = pos_reg;
        first_next  = first_reg;
        stable_next = stable_reg;
        deb_next    = deb_reg;
        fire        = 1'b0;
        if (accept)
        begin
            if (pos_reg == '0)
            begin
                first_next  = sample;
                stable_next = 1'b1;
            end
            else
            begin
                stable_next = stable_reg && (sample == first_reg);
            end
            if (pos_reg == POS_LAST)
            begin
                pos_next = '0;
                // whole window equal and different from the debounced keys
                if (stable_reg && (sample == first_reg) && (sample != deb_reg))
                begin
                    fire     = 1'b1;
                    deb_next = sample;
                end
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    assign pkt_valid   = fire;
    assign pkt.keys    = sample;
    assign pkt.changed = sample ^ deb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            stable_reg <= 1'b0;
            deb_reg    <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            stable_reg <= stable_next;
            deb_reg    <= deb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
    end

endmodule

`default_nettype wire

// ----- src/bdke_queue.sv -----
// two-entry queue of change packets between front and back
`default_nettype none

module bdke_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire bdke_pkg::packet_t in_pkt,
    output logic             out_valid,
    input  wire logic        out_ready,
    output bdke_pkg::packet_t out_pkt
);
    import bdke_pkg::*;

    packet_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_pkt   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_pkt;
        end
    end

endmodule

`default_nettype wire

// ----- src/bdke_back.sv -----
// event serializer: one key event word per cycle while m_tready is high, lowest key first
`default_nettype none

module bdke_back #(
    parameter int KEY_COUNT = bdke_pkg::DEF_KEY_COUNT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          pkt_valid,
    output logic                               pkt_ready,
    input  wire bdke_pkg::packet_t             pkt,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [bdke_pkg::STATE_W-1:0]       state_char,
    output logic [bdke_pkg::KEYCH_W-1:0]       key_char,
    output logic                               m_tlast
);
    import bdke_pkg::*;

    localparam int KEY_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    logic              busy_reg;
    logic [PORT_W-1:0] rem_reg;
    logic [PORT_W-1:0] keys_reg;
    logic              valid_reg;
    logic [STATE_W-1:0] state_reg;
    logic [KEYCH_W-1:0] key_reg;
    logic               last_reg;

    logic [PORT_W-1:0] onehot;
    logic [PORT_W-1:0] rem_after;
    logic [KEY_W-1:0]  idx;
    logic              advance;
    logic              load;

    assign pkt_ready = !busy_reg;
    assign load      = pkt_valid && !busy_reg;
    assign advance   = busy_reg && (!valid_reg || m_tready);

    // isolate lowest pending key
    assign onehot    = rem_reg & (~rem_reg + PORT_W'(1));
    assign rem_after = rem_reg & ~onehot;

    always_comb
    begin
        idx = '0;
        for (int i = KEY_COUNT - 1; i >= 0; i--)
        begin
            if (rem_reg[i])
            begin
                idx = KEY_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= 1'b1;
                rem_reg   <= rem_after;
                busy_reg  <= (rem_after != '0);
            end
            else
            begin
                if (valid_reg && m_tready)
                begin
                    valid_reg <= 1'b0;
                end
                if (load)
                begin
                    rem_reg  <= pkt.changed;
                    busy_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            keys_reg <= pkt.keys;
        end
        if (advance)
        begin
            state_reg <= (|(keys_reg & onehot)) ? CHAR_DOWN : CHAR_UP;
            key_reg   <= CHAR_ZERO + KEYCH_W'(idx);
            last_reg  <= (rem_after == '0);
        end
    end

    assign m_tvalid   = valid_reg;
    assign state_char = state_reg;
    assign key_char   = key_reg;
    assign m_tlast    = last_reg;

endmodule

`default_nettype wire

// ----- src/block_debounce_key_event_encoder_top.sv -----
// top level of the key debounce and key event encoder
`default_nettype none

// Takes one raw active-low key port word per tick and checks it in windows of
// WINDOW_SAMPLES words. When a full window holds one value that differs from
// the debounced keys, one event word is sent for every changed key, lowest
// key first: 'D' or 'U' and the key digit, with tlast on the last event of the
// change. Input words are taken one per cycle while the two-entry change queue
// has room; the queue fills only while events wait downstream. The back end
// loads a change from the queue, then sends one event per cycle while
// m_tready is high, at most KEY_COUNT events for one change.
module block_debounce_key_event_encoder_top #(
    parameter int WINDOW_SAMPLES = bdke_pkg::DEF_WINDOW_SAMPLES,
    parameter int KEY_COUNT      = bdke_pkg::DEF_KEY_COUNT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] raw_port
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [6:0] state_char, [12:7] key_char, [15:13] zero
    output logic             m_tlast    // last_event
);
    import bdke_pkg::*;

    packet_t            front_pkt;
    logic               front_valid;
    logic               front_ready;
    packet_t            back_pkt;
    logic               back_valid;
    logic               back_ready;
    logic [STATE_W-1:0] state_char;
    logic [KEYCH_W-1:0] key_char;

    bdke_front #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES),
        .KEY_COUNT      (KEY_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .raw_port  (s_tdata),
        .pkt_valid (front_valid),
        .pkt_ready (front_ready),
        .pkt       (front_pkt)
    );

    bdke_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_pkt    (front_pkt),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_pkt   (back_pkt)
    );

    bdke_back #(
        .KEY_COUNT (KEY_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_valid  (back_valid),
        .pkt_ready  (back_ready),
        .pkt        (back_pkt),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .state_char (state_char),
        .key_char   (key_char),
        .m_tlast    (m_tlast)
    );

    assign m_tdata = {3'b000, key_char, state_char};

endmodule

`default_nettype wire
